FILE: sv/yrtw_pkg.sv
// ----------------------------------------------------------------------------
// yrtw_pkg
// Shared types and constants for the YCbCr to RGB565 tiled texture writer.
// ----------------------------------------------------------------------------
package yrtw_pkg;

   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int ADDR_W      = 21;
   localparam int PIXEL_W     = 16;
   localparam int SAMPLE_W    = 8;

   // byte offset inside a 32 byte tile takes five bits
   localparam int TILE_SHIFT  = 5;
   localparam int TILE_W      = ADDR_W - TILE_SHIFT;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RST   = 11'd428;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RST  = 11'd240;
   localparam logic [CSR_DATA_W-1:0] TEXTURE_WIDTH_RST = 11'd428;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_TEXTURE_WIDTH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] frame_width;
      logic [CSR_DATA_W-1:0] frame_height;
      logic [CSR_DATA_W-1:0] texture_width;
   } cfg_type;

endpackage

FILE: sv/ycbcr_to_rgb565_tiled_writer.sv
// ----------------------------------------------------------------------------
// ycbcr_to_rgb565_tiled_writer
// Converts a raster YCbCr pixel stream to RGB565 and gives each pixel's byte
// address in a 4x4 tiled texture, flagging the last pixel of the frame.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         valid / stall      luma, blue_diff, red_diff
//  rsp      out        valid / stall      pixel, byte_address, frame_end
//  csr      in         valid / ready      index, data (11 bits)
//
//  One pixel per clock sustained while rsp is not stalled; each req beat
//  goes through the input register, then the result register, to rsp.
//  Position counters advance on each req beat; frame_end is decided there.
//  req_stall rises only while both stages are full and rsp is stalled.
//  Synchronous reset clears counters and valid flags and loads default sizes.
//  csr is always ready; writes are expected only while the pipe is empty.
// ----------------------------------------------------------------------------
module ycbcr_to_rgb565_tiled_writer #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [yrtw_pkg::SAMPLE_W-1:0]       req_luma,
   input  logic [yrtw_pkg::SAMPLE_W-1:0]       req_blue_diff,
   input  logic [yrtw_pkg::SAMPLE_W-1:0]       req_red_diff,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [yrtw_pkg::PIXEL_W-1:0]        rsp_pixel,
   output logic [yrtw_pkg::ADDR_W-1:0]         rsp_byte_address,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [yrtw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [yrtw_pkg::CSR_DATA_W-1:0]     csr_data
);

   // at least three bits so the tile part of a counter always exists
   localparam int COL_W = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 3;
   localparam int ROW_W = (MAX_HEIGHT > 4) ? $clog2(MAX_HEIGHT) : 3;

   yrtw_pkg::cfg_type               cfg_ff;
   yrtw_pkg::cfg_type               cfg_in;

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic [yrtw_pkg::SAMPLE_W-1:0]   s1_luma_ff;
   logic [yrtw_pkg::SAMPLE_W-1:0]   s1_cb_ff;
   logic [yrtw_pkg::SAMPLE_W-1:0]   s1_cr_ff;
   logic [COL_W-1:0]                s1_col_ff;
   logic [ROW_W-1:0]                s1_row_ff;
   logic                            s1_end_ff;

   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [yrtw_pkg::PIXEL_W-1:0]    rsp_pixel_ff;
   logic [yrtw_pkg::ADDR_W-1:0]     rsp_addr_ff;
   logic                            rsp_end_ff;

   logic                            move;
   logic                            req_beat;
   logic [COL_W-1:0]                pos_col;
   logic [ROW_W-1:0]                pos_row;
   logic                            pos_end;
   logic [yrtw_pkg::PIXEL_W-1:0]    conv_pixel;
   logic [yrtw_pkg::ADDR_W-1:0]     conv_addr;

   // config
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (yrtw_pkg::csr_index_type'(csr_index))
            yrtw_pkg::CSR_FRAME_WIDTH:   cfg_in.frame_width   = csr_data;
            yrtw_pkg::CSR_FRAME_HEIGHT:  cfg_in.frame_height  = csr_data;
            yrtw_pkg::CSR_TEXTURE_WIDTH: cfg_in.texture_width = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= yrtw_pkg::FRAME_WIDTH_RST;
         cfg_ff.frame_height  <= yrtw_pkg::FRAME_HEIGHT_RST;
         cfg_ff.texture_width <= yrtw_pkg::TEXTURE_WIDTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline control
   assign move      = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !move;
   assign req_beat  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_beat || (s1_valid_ff && !move);
      rsp_valid_in = move ? s1_valid_ff : rsp_valid_ff;
   end

   yrtw_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W)
   ) u_position (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_beat),
      .cfg       (cfg_ff),
      .col       (pos_col),
      .row       (pos_row),
      .frame_end (pos_end)
   );

   yrtw_color u_color (
      .luma      (s1_luma_ff),
      .blue_diff (s1_cb_ff),
      .red_diff  (s1_cr_ff),
      .pixel     (conv_pixel)
   );

   yrtw_address #(
      .COL_W (COL_W),
      .ROW_W (ROW_W)
   ) u_address (
      .col           (s1_col_ff),
      .row           (s1_row_ff),
      .texture_width (cfg_ff.texture_width),
      .byte_address  (conv_addr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_luma_ff <= req_luma;
         s1_cb_ff   <= req_blue_diff;
         s1_cr_ff   <= req_red_diff;
         s1_col_ff  <= pos_col;
         s1_row_ff  <= pos_row;
         s1_end_ff  <= pos_end;
      end
      if (move && s1_valid_ff) begin
         rsp_pixel_ff <= conv_pixel;
         rsp_addr_ff  <= conv_addr;
         rsp_end_ff   <= s1_end_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel        = rsp_pixel_ff;
   assign rsp_byte_address = rsp_addr_ff;
   assign rsp_frame_end    = rsp_end_ff;

endmodule

FILE: sv/yrtw_color.sv
// ----------------------------------------------------------------------------
// yrtw_color
// BT.601 style YCbCr to RGB565 conversion with floored fixed point terms
// and per channel clamping.
// ----------------------------------------------------------------------------
module yrtw_color (
   input  logic [yrtw_pkg::SAMPLE_W-1:0] luma,
   input  logic [yrtw_pkg::SAMPLE_W-1:0] blue_diff,
   input  logic [yrtw_pkg::SAMPLE_W-1:0] red_diff,
   output logic [yrtw_pkg::PIXEL_W-1:0]  pixel
);

   localparam logic signed [18:0] K_CR_R = 19'sd359;
   localparam logic signed [18:0] K_CB_G = 19'sd88;
   localparam logic signed [18:0] K_CR_G = 19'sd183;
   localparam logic signed [18:0] K_CB_B = 19'sd454;
   localparam logic signed [8:0]  CHROMA_BIAS = 9'sd128;

   function automatic logic [7:0] clamp8(input logic signed [11:0] v);
      logic [7:0] res;
      if (v < 12'sd0) begin
         res = 8'd0;
      end else if (v > 12'sd255) begin
         res = 8'hFF;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   logic signed [8:0]  cb_off;
   logic signed [8:0]  cr_off;
   logic signed [18:0] r_prod;
   logic signed [18:0] gb_prod;
   logic signed [18:0] gr_prod;
   logic signed [18:0] b_prod;
   logic signed [11:0] y_s;
   logic signed [11:0] r_sum;
   logic signed [11:0] g_sum;
   logic signed [11:0] b_sum;
   logic [7:0]         r_ch;
   logic [7:0]         g_ch;
   logic [7:0]         b_ch;

   always_comb begin
      cb_off  = $signed({1'b0, blue_diff}) - CHROMA_BIAS;
      cr_off  = $signed({1'b0, red_diff}) - CHROMA_BIAS;
      r_prod  = 19'(cr_off) * K_CR_R;
      gb_prod = 19'(cb_off) * K_CB_G;
      gr_prod = 19'(cr_off) * K_CR_G;
      b_prod  = 19'(cb_off) * K_CB_B;
      y_s     = $signed({4'd0, luma});
      // arithmetic >> 8 floors: take bits 18:8 and sign extend
      r_sum   = y_s + 12'($signed(r_prod[18:8]));
      g_sum   = y_s - 12'($signed(gb_prod[18:8])) - 12'($signed(gr_prod[18:8]));
      b_sum   = y_s + 12'($signed(b_prod[18:8]));
      r_ch    = clamp8(r_sum);
      g_ch    = clamp8(g_sum);
      b_ch    = clamp8(b_sum);
      pixel   = {r_ch[7:3], g_ch[7:2], b_ch[7:3]};
   end

endmodule

FILE: sv/yrtw_address.sv
// ----------------------------------------------------------------------------
// yrtw_address
// Byte address of a texel in a texture stored as 4x4 tiles of 32 bytes.
// ----------------------------------------------------------------------------
module yrtw_address #(
   parameter int COL_W = 10,
   parameter int ROW_W = 10
) (
   input  logic [COL_W-1:0]                  col,
   input  logic [ROW_W-1:0]                  row,
   input  logic [yrtw_pkg::CSR_DATA_W-1:0]   texture_width,
   output logic [yrtw_pkg::ADDR_W-1:0]       byte_address
);

   localparam int TPR_W  = yrtw_pkg::CSR_DATA_W - 2;
   localparam int PROD_W = ROW_W - 2 + TPR_W;

   logic [TPR_W-1:0]             tile_cols;
   logic [PROD_W-1:0]            row_base;
   logic [yrtw_pkg::TILE_W-1:0]  tile_idx;

   always_comb begin
      tile_cols     = texture_width[yrtw_pkg::CSR_DATA_W-1:2];
      row_base      = row[ROW_W-1:2] * tile_cols;
      tile_idx      = yrtw_pkg::TILE_W'(row_base) + yrtw_pkg::TILE_W'(col[COL_W-1:2]);
      byte_address  = {tile_idx, row[1:0], col[1:0], 1'b0};
   end

endmodule

FILE: sv/yrtw_position.sv
// ----------------------------------------------------------------------------
// yrtw_position
// Raster column and row counters with end of row / end of frame detection.
// ----------------------------------------------------------------------------
module yrtw_position #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COL_W      = 10,
   parameter int ROW_W      = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  yrtw_pkg::cfg_type      cfg,
   output logic [COL_W-1:0]       col,
   output logic [ROW_W-1:0]       row,
   output logic                   frame_end
);

   localparam int WLIM_W = $clog2(MAX_WIDTH + 1);
   localparam int HLIM_W = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP_W = (yrtw_pkg::CSR_DATA_W > WLIM_W) ? yrtw_pkg::CSR_DATA_W : WLIM_W;
   localparam int HCMP_W = (yrtw_pkg::CSR_DATA_W > HLIM_W) ? yrtw_pkg::CSR_DATA_W : HLIM_W;

   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [WCMP_W-1:0] fw;
   logic [WCMP_W-1:0] last_col;
   logic [HCMP_W-1:0] fh;
   logic [HCMP_W-1:0] last_row;
   logic              row_end;

   always_comb begin
      fw = WCMP_W'(cfg.frame_width);
      if (fw == '0) begin
         fw = WCMP_W'(1);
      end else if (fw > WCMP_W'(MAX_WIDTH)) begin
         fw = WCMP_W'(MAX_WIDTH);
      end
      fh = HCMP_W'(cfg.frame_height);
      if (fh == '0) begin
         fh = HCMP_W'(1);
      end else if (fh > HCMP_W'(MAX_HEIGHT)) begin
         fh = HCMP_W'(MAX_HEIGHT);
      end
      last_col  = fw - WCMP_W'(1);
      last_row  = fh - HCMP_W'(1);
      row_end   = WCMP_W'(col_ff) >= last_col;
      frame_end = row_end && (HCMP_W'(row_ff) >= last_row);
      col_in    = col_ff;
      row_in    = row_ff;
      if (advance) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = col_ff;
   assign row = row_ff;

endmodule

FILE: sv/yrtw_checker.sv
// ----------------------------------------------------------------------------
// yrtw_checker
// Port level checks for the tiled writer: rsp hold under stall, occupancy,
// backpressure and frame start addressing.
// ----------------------------------------------------------------------------
module yrtw_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [yrtw_pkg::PIXEL_W-1:0]     rsp_pixel,
   input  logic [yrtw_pkg::ADDR_W-1:0]      rsp_byte_address,
   input  logic                             rsp_frame_end
);

   logic [1:0] occ_ff;
   logic [1:0] occ_in;
   logic       start_ff;
   logic       start_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   always_comb begin
      occ_in = occ_ff;
      if (req_beat && !rsp_beat) begin
         occ_in = occ_ff + 2'd1;
      end else if (rsp_beat && !req_beat) begin
         occ_in = occ_ff - 2'd1;
      end
      start_in = rsp_beat ? rsp_frame_end : start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         start_ff <= 1'b1;
      end else begin
         occ_ff   <= occ_in;
         start_ff <= start_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel)
         && $stable(rsp_byte_address) && $stable(rsp_frame_end))
      else $error("rsp beat changed while stalled");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= 2'd2 && (!rsp_valid || occ_ff != 2'd0))
      else $error("pipeline occupancy out of range");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without output backpressure");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && start_ff |-> rsp_byte_address == '0)
      else $error("first pixel of frame not at address zero");

endmodule

bind ycbcr_to_rgb565_tiled_writer yrtw_checker u_yrtw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pixel        (rsp_pixel),
   .rsp_byte_address (rsp_byte_address),
   .rsp_frame_end    (rsp_frame_end)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the YCbCr to RGB565 tiled texture writer. An
// in-bench model converts each accepted pixel and tracks the frame position
// and tiled address. Results are compared beat by beat under random
// idling on both sides, directed corner cases and random frame settings.
// ----------------------------------------------------------------------------
module tb;

   localparam int FRAME_MAX_W  = 1024;
   localparam int FRAME_MAX_H  = 1024;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int LONG_HOLD    = 300;
   localparam int PIPE_SETTLE  = 4;
   localparam int TALL_RUN     = 320;
   localparam logic [yrtw_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [yrtw_pkg::PIXEL_W-1:0] pixel;
      logic [yrtw_pkg::ADDR_W-1:0]  byte_address;
      logic                         frame_end;
   } texel_beat_type;

   logic                                clock;
   logic                                reset         = 1'b1;
   logic                                req_valid     = 1'b0;
   logic                                req_stall;
   logic [yrtw_pkg::SAMPLE_W-1:0]       req_luma      = '0;
   logic [yrtw_pkg::SAMPLE_W-1:0]       req_blue_diff = '0;
   logic [yrtw_pkg::SAMPLE_W-1:0]       req_red_diff  = '0;
   logic                                rsp_valid;
   logic                                rsp_stall     = 1'b0;
   logic [yrtw_pkg::PIXEL_W-1:0]        rsp_pixel;
   logic [yrtw_pkg::ADDR_W-1:0]         rsp_byte_address;
   logic                                rsp_frame_end;
   logic                                csr_valid     = 1'b0;
   logic                                csr_ready;
   logic [yrtw_pkg::CSR_INDEX_W-1:0]    csr_index     = '0;
   logic [yrtw_pkg::CSR_DATA_W-1:0]     csr_data      = '0;

   yrtw_pkg::cfg_type shadow_cfg;
   int                pos_col;
   int                pos_row;
   texel_beat_type    pending_texels[$];
   texel_beat_type    want_texel;
   int                failures    = 0;
   int                cycle_count = 0;
   bit                tx_gaps     = 1'b1;
   bit                rx_gaps     = 1'b1;
   bit                hold_rsp    = 1'b0;

   ycbcr_to_rgb565_tiled_writer #(
      .MAX_WIDTH (FRAME_MAX_W),
      .MAX_HEIGHT(FRAME_MAX_H)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_luma        (req_luma),
      .req_blue_diff   (req_blue_diff),
      .req_red_diff    (req_red_diff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel       (rsp_pixel),
      .rsp_byte_address(rsp_byte_address),
      .rsp_frame_end   (rsp_frame_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---- color and placement model ----

   function automatic logic [7:0] clamp_channel(input int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   function automatic logic [yrtw_pkg::PIXEL_W-1:0] ycbcr_to_rgb565(
      input logic [yrtw_pkg::SAMPLE_W-1:0] y, cb, cr);
      int d, c;
      logic [7:0] r8, g8, b8;
      d  = int'(cb) - 128;
      c  = int'(cr) - 128;
      r8 = clamp_channel(int'(y) + ((359 * c) >>> 8));
      g8 = clamp_channel(int'(y) - ((88 * d) >>> 8) - ((183 * c) >>> 8));
      b8 = clamp_channel(int'(y) + ((454 * d) >>> 8));
      return {r8[7:3], g8[7:2], b8[7:3]};
   endfunction

   function automatic int clip_size(input logic [yrtw_pkg::CSR_DATA_W-1:0] v,
                                    input int maxv);
      if (v == 0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic void predict_texel(input logic [yrtw_pkg::SAMPLE_W-1:0] y, cb, cr);
      texel_beat_type t;
      int tiles, addr, last_col, last_row;
      bit row_done;
      tiles    = int'(shadow_cfg.texture_width) >> 2;
      addr     = ((pos_row >> 2) * tiles + (pos_col >> 2)) * 32
                 + ((pos_row % 4) * 4 + (pos_col % 4)) * 2;
      last_col = clip_size(shadow_cfg.frame_width, FRAME_MAX_W) - 1;
      last_row = clip_size(shadow_cfg.frame_height, FRAME_MAX_H) - 1;
      row_done = pos_col >= last_col;
      t.pixel        = ycbcr_to_rgb565(y, cb, cr);
      t.byte_address = addr[yrtw_pkg::ADDR_W-1:0];
      t.frame_end    = row_done && pos_row >= last_row;
      if (row_done) begin
         pos_col = 0;
         pos_row = t.frame_end ? 0 : pos_row + 1;
      end else begin
         pos_col++;
      end
      pending_texels.push_back(t);
   endfunction

   // ---- result checking ----

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_texels.size() == 0) begin
            $error("unexpected result beat: pixel %h address %h", rsp_pixel,
                   rsp_byte_address);
            failures++;
         end else begin
            want_texel = pending_texels.pop_front();
            if (rsp_pixel !== want_texel.pixel) begin
               $error("pixel expected %h actual %h", want_texel.pixel, rsp_pixel);
               failures++;
            end
            if (rsp_byte_address !== want_texel.byte_address) begin
               $error("byte_address expected %h actual %h", want_texel.byte_address,
                      rsp_byte_address);
               failures++;
            end
            if (rsp_frame_end !== want_texel.frame_end) begin
               $error("frame_end expected %b actual %b", want_texel.frame_end,
                      rsp_frame_end);
               failures++;
            end
         end
      end
   end

   // ---- result side stalls ----

   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---- drivers ----

   task automatic send_pixel(input logic [yrtw_pkg::SAMPLE_W-1:0] y, cb, cr);
      if (tx_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_luma      <= y;
      req_blue_diff <= cb;
      req_red_diff  <= cr;
      do @(posedge clock); while (req_stall);
      predict_texel(y, cb, cr);
   endtask

   task automatic send_random_pixels(input int count);
      repeat (count)
         send_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   task automatic wait_pipe_empty();
      req_valid <= 1'b0;
      while (pending_texels.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [yrtw_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [yrtw_pkg::CSR_DATA_W-1:0] value);
      wait_pipe_empty();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         yrtw_pkg::CSR_FRAME_WIDTH:   shadow_cfg.frame_width   = value;
         yrtw_pkg::CSR_FRAME_HEIGHT:  shadow_cfg.frame_height  = value;
         yrtw_pkg::CSR_TEXTURE_WIDTH: shadow_cfg.texture_width = value;
         default: ;
      endcase
   endtask

   task automatic set_frame(input int fw, fh, tw);
      write_reg(yrtw_pkg::CSR_FRAME_WIDTH, fw[yrtw_pkg::CSR_DATA_W-1:0]);
      write_reg(yrtw_pkg::CSR_FRAME_HEIGHT, fh[yrtw_pkg::CSR_DATA_W-1:0]);
      write_reg(yrtw_pkg::CSR_TEXTURE_WIDTH, tw[yrtw_pkg::CSR_DATA_W-1:0]);
   endtask

   function automatic int pick_size(input int typical);
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return $urandom_range(FRAME_MAX_W + 1, 2047);
         2:       return 1;
         default: return $urandom_range(2, typical);
      endcase
   endfunction

   // ---- tests ----

   task automatic test_color_corners();
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0,   8'd128, 8'd128);
      send_pixel(8'd255, 8'd128, 8'd128);
      send_pixel(8'd128, 8'd0,   8'd0);
      send_pixel(8'd128, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd0,   8'd255);
      send_pixel(8'd128, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd0,   8'd255, 8'd0);
   endtask

   task automatic test_unused_index();
      write_reg(CSR_SPARE, 11'h7FF);
      send_pixel(8'd16, 8'd128, 8'd128);
   endtask

   // counters sit past the new last column and row when sizes shrink
   task automatic test_shrink_midframe();
      set_frame(6, 4, 8);
      send_random_pixels(10);
      write_reg(yrtw_pkg::CSR_FRAME_WIDTH, 11'd2);
      write_reg(yrtw_pkg::CSR_FRAME_HEIGHT, 11'd1);
      send_random_pixels(4);
   endtask

   task automatic test_narrow_texture();
      set_frame(1, 8, 0);
      send_random_pixels(8);
      write_reg(yrtw_pkg::CSR_TEXTURE_WIDTH, 11'd3);
      send_random_pixels(8);
   endtask

   task automatic test_size_clipping();
      set_frame(0, 0, 4);
      send_random_pixels(3);
   endtask

   task automatic test_full_size_frames();
      set_frame(2047, 1, $urandom_range(0, 2047));
      send_random_pixels(FRAME_MAX_W);
      set_frame(1, 2047, 2047);
      send_random_pixels(TALL_RUN);
   endtask

   task automatic test_output_backpressure();
      set_frame(16, 4, 16);
      tx_gaps  = 1'b0;
      hold_rsp = 1'b1;
      send_random_pixels(40);
      tx_gaps  = 1'b1;
   endtask

   task automatic test_random_frames();
      for (int phase = 0; phase < 10; phase++) begin
         if (phase >= 7) begin
            tx_gaps = 1'b0;
            rx_gaps = 1'b0;
         end
         set_frame(pick_size(10), pick_size(5), pick_size(64));
         send_random_pixels(45);
      end
   endtask

   initial begin
      shadow_cfg.frame_width   = yrtw_pkg::FRAME_WIDTH_RST;
      shadow_cfg.frame_height  = yrtw_pkg::FRAME_HEIGHT_RST;
      shadow_cfg.texture_width = yrtw_pkg::TEXTURE_WIDTH_RST;
      pos_col = 0;
      pos_row = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_color_corners();
      test_unused_index();
      test_shrink_midframe();
      test_narrow_texture();
      test_size_clipping();
      test_full_size_frames();
      test_output_backpressure();
      test_random_frames();

      wait_pipe_empty();
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
